>>> rtl/slbr_pkg.sv
package slbr_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned WORD_W  = 24;

  // Cycles from the pending level registers to a settled lane length.
  localparam int unsigned LANE_LAT = 3;

  // Configuration register indexes.
  localparam logic CFG_SENSITIVITY    = 1'b0;
  localparam logic CFG_MAX_BRIGHTNESS = 1'b1;

  localparam logic [CFG_W-1:0] SENSITIVITY_RST    = 8'd1;
  localparam logic [CFG_W-1:0] MAX_BRIGHTNESS_RST = 8'd255;

  typedef struct packed {
    logic [LEVEL_W-1:0] right_level;
    logic [LEVEL_W-1:0] left_level;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  pixel_index;
    logic [WORD_W-1:0] pixel_word;
    logic              last_pixel;
  } out_t;

  // Bar lengths of one frame, handed from the lanes to the pixel emitter.
  typedef struct packed {
    logic [LEN_W-1:0] right_len;
    logic [LEN_W-1:0] left_len;
  } frame_t;

endpackage

>>> rtl/stereo_level_bar_renderer.sv
// Stereo level bar renderer for an LED strip VU meter.
// Input channel: one transaction per frame carries the right and left channel
// levels (in_valid_i / in_stall_o / in_data_i). Output channel: one transaction
// per strip pixel, in pixel order, with last_pixel set on the final pixel
// (out_valid_o / out_stall_i / out_data_o).
// Config: cfg_we_i writes sensitivity (index 0) or max_brightness (index 1);
// write only while no frame is in flight.
// Path from an accepted frame to its first pixel when the block is idle: three lane
// stages, hand-off into the emitter frame register, two emitter stages. The pixel
// emitter issues one pixel per cycle while out_stall_i does not hold it. One frame
// waits in the pending register while the previous one is emitted, so frames
// can stream back to back.
// Reset: clears all valid state, sensitivity to 1, max_brightness to 255.
// Out stall freezes the whole emitter pipeline; nothing is dropped, and the
// pending frame then holds in_stall_o high.
module stereo_level_bar_renderer #(
  parameter int unsigned STRIP_PIXELS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  slbr_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output slbr_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [slbr_pkg::CFG_W-1:0]  cfg_data_i
);

  logic [slbr_pkg::CFG_W-1:0] sens_q;
  logic [slbr_pkg::CFG_W-1:0] max_bright_q;

  // pending frame and the age of its lane results
  logic          pend_valid_q;
  logic [1:0]    pend_age_q;
  slbr_pkg::in_t pend_q;

  logic                       in_accept;
  logic                       frame_take;
  logic                       frame_ready;
  logic [slbr_pkg::LEN_W-1:0] right_len;
  logic [slbr_pkg::LEN_W-1:0] left_len;
  slbr_pkg::frame_t           frame;

  assign in_accept   = in_valid_i && !pend_valid_q;
  assign frame_ready = pend_valid_q && (pend_age_q == 2'(slbr_pkg::LANE_LAT));
  assign in_stall_o  = pend_valid_q;
  assign frame       = {right_len, left_len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q       <= slbr_pkg::SENSITIVITY_RST;
      max_bright_q <= slbr_pkg::MAX_BRIGHTNESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slbr_pkg::CFG_SENSITIVITY:    sens_q       <= cfg_data_i;
        slbr_pkg::CFG_MAX_BRIGHTNESS: max_bright_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_age_q   <= '0;
    end else begin
      if (in_accept) begin
        pend_valid_q <= 1'b1;
        pend_age_q   <= '0;
      end else begin
        if (frame_take) begin
          pend_valid_q <= 1'b0;
        end
        if (pend_valid_q && !frame_ready) begin
          pend_age_q <= pend_age_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q <= in_data_i;
    end
  end

  // one lane per channel
  slbr_lane #(.STRIP_PIXELS(STRIP_PIXELS)) u_lane_right (
    .clk_i   (clk_i),
    .sens_i  (sens_q),
    .level_i (pend_q.right_level),
    .len_o   (right_len)
  );

  slbr_lane #(.STRIP_PIXELS(STRIP_PIXELS)) u_lane_left (
    .clk_i   (clk_i),
    .sens_i  (sens_q),
    .level_i (pend_q.left_level),
    .len_o   (left_len)
  );

  // merges both bar lengths into the pixel stream
  slbr_emit #(.STRIP_PIXELS(STRIP_PIXELS)) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_bright_i  (max_bright_q),
    .frame_valid_i (frame_ready),
    .frame_i       (frame),
    .frame_take_o  (frame_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

>>> rtl/slbr_lane.sv
module slbr_lane #(
  parameter int unsigned STRIP_PIXELS = 32
) (
  input  logic                          clk_i,
  input  logic [slbr_pkg::CFG_W-1:0]    sens_i,
  input  logic [slbr_pkg::LEVEL_W-1:0]  level_i,
  output logic [slbr_pkg::LEN_W-1:0]    len_o
);

  localparam int unsigned HALF = STRIP_PIXELS / 2;
  localparam logic [slbr_pkg::LEN_W-1:0] HALF_L = slbr_pkg::LEN_W'(HALF);

  logic [23:0] prod_q;
  logic [29:0] x_q;
  logic [slbr_pkg::LEN_W-1:0] len_q;

  logic [13:0] hi;
  logic [15:0] lo;
  logic [16:0] sum;
  logic [13:0] quo;
  logic [slbr_pkg::LEN_W-1:0] len_d;

  // x / 65535 with x = hi*65536 + lo: quotient is hi, plus one when hi + lo
  // reaches 65535 (hi + lo stays below twice that).
  always_comb begin
    hi    = x_q[29:16];
    lo    = x_q[15:0];
    sum   = 17'(hi) + 17'(lo);
    quo   = hi + 14'(sum >= 17'd65535);
    len_d = (quo > 14'(HALF)) ? HALF_L : quo[slbr_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 24'(sens_i) * 24'(level_i);
    x_q    <= 30'(prod_q) * 30'(HALF_L);
    len_q  <= len_d;
  end

  assign len_o = len_q;

endmodule

>>> rtl/slbr_emit.sv
module slbr_emit #(
  parameter int unsigned STRIP_PIXELS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [slbr_pkg::CFG_W-1:0]  max_bright_i,
  input  logic                        frame_valid_i,
  input  slbr_pkg::frame_t            frame_i,
  output logic                        frame_take_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output slbr_pkg::out_t              out_data_o
);

  localparam int unsigned HALF = STRIP_PIXELS / 2;
  localparam int unsigned RECIP_SH = 20;
  // ceil(2^20 / HALF): exact quotient for products below HALF * 256
  localparam int unsigned RECIP = ((1 << RECIP_SH) + HALF - 1) / HALF;
  localparam logic [slbr_pkg::IDX_W-1:0] LAST_P = slbr_pkg::IDX_W'(STRIP_PIXELS - 1);

  logic                         busy_q;
  logic [slbr_pkg::IDX_W-1:0]   p_q;
  slbr_pkg::frame_t             frame_q;

  logic                         v1_q;
  logic [slbr_pkg::IDX_W-1:0]   idx1_q;
  logic                         lit1_q;
  logic                         last1_q;
  logic [13:0]                  prod1_q;

  logic                         out_valid_q;
  slbr_pkg::out_t               out_q;

  logic                         adv;
  logic                         issue;
  logic                         take;
  logic [slbr_pkg::IDX_W-1:0]   from_far;
  logic                         lit_r;
  logic                         lit_l;
  logic [slbr_pkg::IDX_W-1:0]   span;
  logic [13:0]                  prod1_d;
  logic [34:0]                  recip_mul;
  logic [7:0]                   grad;
  logic [slbr_pkg::WORD_W-1:0]  word;

  always_comb begin
    adv      = !out_valid_q || !out_stall_i;
    issue    = busy_q && adv;
    take     = frame_valid_i && adv && (!busy_q || p_q == LAST_P);
    from_far = LAST_P - p_q;
    lit_r    = p_q < frame_q.right_len;
    lit_l    = from_far < frame_q.left_len;
    span     = lit_r ? p_q : from_far;
    prod1_d  = 14'(span) * 14'(max_bright_i);
    recip_mul = 35'(prod1_q) * 35'(RECIP);
    grad     = recip_mul[RECIP_SH+7:RECIP_SH];
    word     = lit1_q ? {max_bright_i - grad, grad, 8'h00} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      p_q         <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        p_q    <= '0;
      end else if (issue) begin
        if (p_q == LAST_P) begin
          busy_q <= 1'b0;
        end
        p_q <= p_q + 1'b1;
      end
      if (adv) begin
        v1_q        <= issue;
        out_valid_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      frame_q <= frame_i;
    end
    if (adv) begin
      idx1_q  <= p_q;
      lit1_q  <= lit_r || lit_l;
      last1_q <= p_q == LAST_P;
      prod1_q <= prod1_d;
      out_q.pixel_index <= idx1_q;
      out_q.pixel_word  <= word;
      out_q.last_pixel  <= last1_q;
    end
  end

  assign frame_take_o = take;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int unsigned PIXELS = 32;
  localparam int unsigned HALF   = PIXELS / 2;
  // Full-scale level used as the divisor of the bar length.
  localparam longint unsigned LEVEL_FS = 65535;

  // Expected-pixel store plus a shadow copy of both registers.
  // A frame is expanded into its whole strip once the sender sees in_stall_o low.
  class bar_scoreboard;
    logic [slbr_pkg::CFG_W-1:0] gain = slbr_pkg::SENSITIVITY_RST;
    logic [slbr_pkg::CFG_W-1:0] peak = slbr_pkg::MAX_BRIGHTNESS_RST;
    slbr_pkg::out_t             strip_q[$];
    int unsigned                errors = 0;

    function int unsigned bar_len(logic [slbr_pkg::LEVEL_W-1:0] lvl);
      longint unsigned len;
      len = (longint'(gain) * HALF * longint'(lvl)) / LEVEL_FS;
      if (len > HALF) len = HALF;
      return int'(len);
    endfunction

    // Gradient: green share grows with distance, red is what is left.
    function logic [slbr_pkg::WORD_W-1:0] shade(int unsigned span);
      int unsigned c;
      int unsigned rest;
      c    = span * peak / HALF;
      rest = peak - c;
      return {rest[7:0], c[7:0], 8'h00};
    endfunction

    function void note_frame(slbr_pkg::in_t f);
      int unsigned    r_len;
      int unsigned    l_len;
      int unsigned    far;
      slbr_pkg::out_t px;
      r_len = bar_len(f.right_level);
      l_len = bar_len(f.left_level);
      for (int unsigned p = 0; p < PIXELS; p++) begin
        far            = PIXELS - 1 - p;
        px.pixel_index = slbr_pkg::IDX_W'(p);
        px.pixel_word  = '0;
        if (p < r_len) begin
          px.pixel_word = shade(p);
        end else if (far < l_len) begin
          px.pixel_word = shade(far);
        end
        px.last_pixel = (p == PIXELS - 1);
        strip_q = {strip_q, px};
      end
    endfunction

    function void check_pixel(slbr_pkg::out_t got);
      slbr_pkg::out_t exp_px;
      if (strip_q.size() == 0) begin
        $error("pixel %0d arrived with no pixel expected", got.pixel_index);
        errors++;
        return;
      end
      exp_px = strip_q.pop_front();
      if (got.pixel_index !== exp_px.pixel_index) begin
        $error("pixel_index: expected %0d, got %0d", exp_px.pixel_index, got.pixel_index);
        errors++;
      end
      if (got.pixel_word !== exp_px.pixel_word) begin
        $error("pixel_word: expected %06h, got %06h", exp_px.pixel_word, got.pixel_word);
        errors++;
      end
      if (got.last_pixel !== exp_px.last_pixel) begin
        $error("last_pixel: expected %0b, got %0b", exp_px.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return strip_q.size();
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  slbr_pkg::in_t              in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b1;
  slbr_pkg::out_t             out_data_o;
  logic                       cfg_we_i    = 1'b0;
  logic                       cfg_idx_i   = slbr_pkg::CFG_SENSITIVITY;
  logic [slbr_pkg::CFG_W-1:0] cfg_data_i  = '0;

  bar_scoreboard board = new;

  // No-idle stretch: both sides run flat out while this is set.
  bit no_idle  = 1'b0;
  // Sender asks the pixel side for one long hold-off; pixel side clears it.
  bit hold_out = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stereo_level_bar_renderer #(
    .STRIP_PIXELS(PIXELS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Pixel monitor: sampled at the edge, before any NBA lands, so race free.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_pixel(out_data_o);
    end
  end

  // Pixel side: random stall before every transaction, one long hold on request.
  // Only one NBA to out_stall_i per time step on every path.
  initial begin : pixel_sink
    int unsigned hold_cyc;
    @(posedge rst_ni);
    forever begin
      hold_cyc = no_idle ? 0 : $urandom_range(0, 14);
      if (hold_out) begin
        hold_cyc = 400;   // long enough to back up the emitter and pending frame
        hold_out = 1'b0;
      end
      if (hold_cyc > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cyc) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // One frame transaction. A zero gap keeps valid high straight into the next frame.
  task automatic send_frame(logic [slbr_pkg::LEVEL_W-1:0] right,
                            logic [slbr_pkg::LEVEL_W-1:0] left);
    int unsigned   gap;
    slbr_pkg::in_t f;
    gap           = no_idle ? 0 : $urandom_range(0, 14);
    f.right_level = right;
    f.left_level  = left;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_frame(f);
  endtask

  // Sender stops until the strip queue is empty, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Both registers in two back-to-back writes; only legal with the block idle.
  task automatic set_regs(logic [slbr_pkg::CFG_W-1:0] gain,
                          logic [slbr_pkg::CFG_W-1:0] peak);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= slbr_pkg::CFG_SENSITIVITY;
    cfg_data_i <= gain;
    @(posedge clk_i);
    cfg_idx_i  <= slbr_pkg::CFG_MAX_BRIGHTNESS;
    cfg_data_i <= peak;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.gain = gain;
    board.peak = peak;
    @(posedge clk_i);
  endtask

  // Spread of levels: full range, shifted down for short bars, extremes.
  function automatic logic [slbr_pkg::LEVEL_W-1:0] pick_level();
    logic [slbr_pkg::LEVEL_W-1:0] lvl;
    lvl = slbr_pkg::LEVEL_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0:       lvl = '0;
      1:       lvl = '1;
      2, 3:    lvl = lvl >> $urandom_range(1, 15);
      default: ;
    endcase
    return lvl;
  endfunction

  initial begin : stimulus
    logic [slbr_pkg::CFG_W-1:0] gain;
    logic [slbr_pkg::CFG_W-1:0] peak;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers (gain 1, full brightness): dark strip, full bars,
    // one side only, partial bars and alternating bit patterns.
    send_frame(16'd0,     16'd0);
    send_frame(16'hFFFF,  16'hFFFF);
    send_frame(16'hFFFF,  16'd0);
    send_frame(16'd0,     16'hFFFF);
    send_frame(16'd32767, 16'd4096);
    send_frame(16'h5555,  16'hAAAA);
    send_frame(16'd4095,  16'd61439);
    drain();

    // Zero sensitivity: whole strip dark whatever the level.
    set_regs(8'd0, 8'd255);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd1234, 16'd40000);
    drain();

    // Zero brightness: lit pixels still carry a zero word.
    set_regs(8'd255, 8'd0);
    send_frame(16'hFFFF, 16'd300);
    send_frame(16'd100,  16'd0);
    drain();

    // Top gain: full bar right at the boundary (257 reaches it exactly, 256 does not).
    set_regs(8'd255, 8'd255);
    send_frame(16'd257, 16'd256);
    send_frame(16'd1,   16'hFFFF);
    send_frame(16'd128, 16'd4000);
    drain();

    set_regs(8'd3, 8'd100);
    send_frame(16'd40000, 16'd20000);
    send_frame(16'hFFFF,  16'hFFFF);
    drain();

    // Random phases, each with fresh register values, drained in between.
    for (int ph = 0; ph < 6; ph++) begin
      gain = slbr_pkg::CFG_W'($urandom_range(1, 24));
      peak = slbr_pkg::CFG_W'($urandom_range(0, 255));
      if (ph == 4) begin
        gain = 8'd255;
        peak = 8'd255;
      end
      set_regs(gain, peak);
      no_idle = (ph == 1);
      for (int k = 0; k < 25; k++) begin
        // Mid-phase long hold on the pixel side while frames keep coming.
        if (ph == 2 && k == 3) hold_out = 1'b1;
        send_frame(pick_level(), pick_level());
      end
      drain();
      no_idle = 1'b0;
    end

    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: ends the run as a failure if the stimulus never finishes.
  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
